// File: design/atatf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA task-file builder package
// Shared payload types, register select codes, addressing modes and the
// constants used to build the task-file writes.
// ----------------------------------------------------------------------------
package atatf_pkg;

   // Task-file register select, in the order the writes go out
   typedef enum logic [3:0] {
      SEL_DEVSEL      = 4'd0,
      SEL_SECCOUNT_HI = 4'd1,
      SEL_LBA3        = 4'd2,
      SEL_LBA4        = 4'd3,
      SEL_LBA5        = 4'd4,
      SEL_SECCOUNT    = 4'd5,
      SEL_LBA0        = 4'd6,
      SEL_LBA1        = 4'd7,
      SEL_LBA2        = 4'd8,
      SEL_COMMAND     = 4'd9
   } reg_sel_type;

   typedef enum logic [1:0] {
      MODE_CHS   = 2'd0,
      MODE_LBA28 = 2'd1,
      MODE_LBA48 = 2'd2
   } addr_mode_type;

   localparam logic [31:0] LBA48_LIMIT  = 32'h1000_0000;
   localparam int          CHS_ADDR_W   = 28;
   localparam int          CHS_QUOT_W   = 23;
   // floor(x / 63) == (x * CHS_RECIP) >> CHS_SHIFT for every 28-bit x
   localparam logic [28:0] CHS_RECIP    = 29'd272696337;
   localparam int          CHS_SHIFT    = 34;
   localparam int          CHS_PROD_W   = 57;

   localparam logic [7:0]  DEV_BASE_CHS = 8'hA0;
   localparam logic [7:0]  DEV_BASE_LBA = 8'hE0;

   localparam logic [7:0]  CMD_RD       = 8'h20;
   localparam logic [7:0]  CMD_RD_EXT   = 8'h24;
   localparam logic [7:0]  CMD_WR       = 8'h30;
   localparam logic [7:0]  CMD_WR_EXT   = 8'h34;

   typedef struct packed {
      logic        write_dir;
      logic        slave_bit;
      logic        lba_capable;
      logic [31:0] block_addr;
      logic [7:0]  sector_count;
   } req_type;

   typedef struct packed {
      logic [3:0] reg_select;
      logic [7:0] reg_value;
      logic [1:0] addr_mode;
      logic       last;
   } rsp_type;

   // Everything the sequencer needs to emit one request's writes
   typedef struct packed {
      addr_mode_type mode;
      logic [7:0]    dev;
      logic [7:0]    cnt;
      logic [7:0]    b0;
      logic [7:0]    b1;
      logic [7:0]    b2;
      logic [7:0]    b3;
      logic [7:0]    cmd;
   } frame_type;

endpackage

// File: design/ata_taskfile_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA task-file builder
// Turns one PIO sector request into the ordered task-file register writes:
// device select, the LBA48 high bytes where needed, sector count, LBA bytes
// 0 to 2 and the read or write command.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_data (atatf_pkg::req_type)
//   rsp       out        rsp_valid / rsp_ready   rsp_data (atatf_pkg::rsp_type)
//
// An accepted request lands in the input register. When the sequencer is free
// it is decoded (mode pick, CHS split by reciprocal multiply) into the
// sequencer's frame register, which then issues one write per cycle, while
// rsp_ready does not stall it, into the result register: 10 writes per
// request for LBA48, 6 for LBA28 and CHS. The first write passes through
// the input, frame and result registers in turn. The next request loads into
// the frame register in the same cycle the command write issues, so requests
// run back to back with no gap. Reset clears only the valid flags and the step counter.
// A stalled rsp_ready holds the result register, the frame and, once the
// input register is full, req_ready.
// ----------------------------------------------------------------------------
module ata_taskfile_builder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  atatf_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output atatf_pkg::rsp_type rsp_data
);
   import atatf_pkg::*;

   // Input register
   req_type   in_ff, in_in;
   logic      in_valid_ff, in_valid_in;

   logic      accept;
   logic      frame_ready;
   frame_type frame;

   always_comb begin
      // take a new item when the register is empty or the held one moves into the sequencer
      req_ready   = !in_valid_ff || frame_ready;
      accept      = req_valid && req_ready;
      in_in       = accept ? req_data : in_ff;
      in_valid_in = accept ? 1'b1 : (frame_ready ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   // Decode held request into the full set of task-file bytes
   atatf_decode u_decode (
      .req   (in_ff),
      .frame (frame)
   );

   // Step through the writes and drive the result register
   atatf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (in_valid_ff),
      .frame_ready (frame_ready),
      .frame       (frame),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// File: design/atatf_chs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHS address split
// Splits a 28-bit block address into sector, head and cylinder for a
// geometry of 63 sectors per track and 16 heads.
// ----------------------------------------------------------------------------
module atatf_chs (
   input  logic [atatf_pkg::CHS_ADDR_W-1:0] addr,
   output logic [7:0]                       sect,
   output logic [3:0]                       head,
   output logic [15:0]                      cyl
);
   import atatf_pkg::*;

   logic [CHS_PROD_W-1:0]   prod;
   logic [CHS_QUOT_W-1:0]   quot;
   logic [CHS_ADDR_W:0]     quot_x63;
   logic [CHS_ADDR_W-1:0]   rem_full;

   always_comb begin
      // track index = addr / 63 by reciprocal multiply
      prod     = CHS_PROD_W'(addr) * CHS_PROD_W'(CHS_RECIP);
      quot     = prod[CHS_SHIFT +: CHS_QUOT_W];
      // quot * 63 = quot * 64 - quot
      quot_x63 = {quot, 6'b000000} - (CHS_ADDR_W + 1)'(quot);
      rem_full = addr - quot_x63[CHS_ADDR_W-1:0];
      sect     = {2'b00, rem_full[5:0]} + 8'd1;
      head     = quot[3:0];
      cyl      = quot[19:4];
   end

endmodule

// File: design/atatf_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request decode
// Picks the addressing mode and forms every task-file byte of one request.
// ----------------------------------------------------------------------------
module atatf_decode (
   input  atatf_pkg::req_type   req,
   output atatf_pkg::frame_type frame
);
   import atatf_pkg::*;

   logic [7:0] chs_sect;
   logic [3:0] chs_head;
   logic [15:0] chs_cyl;
   logic       is_lba48;
   logic [3:0] head;

   atatf_chs u_chs (
      .addr (req.block_addr[CHS_ADDR_W-1:0]),
      .sect (chs_sect),
      .head (chs_head),
      .cyl  (chs_cyl)
   );

   always_comb begin
      is_lba48 = (req.block_addr >= LBA48_LIMIT);
      frame    = '0;
      frame.cnt = req.sector_count;
      if (is_lba48) begin
         frame.mode = MODE_LBA48;
         head       = 4'd0;
         frame.b0   = req.block_addr[7:0];
         frame.b1   = req.block_addr[15:8];
         frame.b2   = req.block_addr[23:16];
         frame.b3   = req.block_addr[31:24];
         frame.cmd  = req.write_dir ? CMD_WR_EXT : CMD_RD_EXT;
      end else if (req.lba_capable) begin
         frame.mode = MODE_LBA28;
         head       = req.block_addr[27:24];
         frame.b0   = req.block_addr[7:0];
         frame.b1   = req.block_addr[15:8];
         frame.b2   = req.block_addr[23:16];
         frame.b3   = 8'd0;
         frame.cmd  = req.write_dir ? CMD_WR : CMD_RD;
      end else begin
         frame.mode = MODE_CHS;
         head       = chs_head;
         frame.b0   = chs_sect;
         frame.b1   = chs_cyl[7:0];
         frame.b2   = chs_cyl[15:8];
         frame.b3   = 8'd0;
         frame.cmd  = req.write_dir ? CMD_WR : CMD_RD;
      end
      frame.dev = ((frame.mode == MODE_CHS) ? DEV_BASE_CHS : DEV_BASE_LBA)
                | {3'b000, req.slave_bit, head};
   end

endmodule

// File: design/atatf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Write sequencer
// Holds one decoded request and steps through its task-file writes, one per
// cycle into the result register, holding while rsp_ready stalls it.
// ----------------------------------------------------------------------------
module atatf_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_valid,
   output logic                 frame_ready,
   input  atatf_pkg::frame_type frame,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output atatf_pkg::rsp_type   rsp_data
);
   import atatf_pkg::*;

   frame_type   frame_ff, frame_in;
   logic        frame_valid_ff, frame_valid_in;
   reg_sel_type step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        out_free;
   logic        issue;
   logic        at_cmd;
   logic        load;
   reg_sel_type step_next;
   logic [7:0]  value;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      issue       = frame_valid_ff && out_free;
      at_cmd      = (step_ff == SEL_COMMAND);
      frame_ready = !frame_valid_ff || (issue && at_cmd);
      load        = frame_valid && frame_ready;

      unique case (step_ff)
         SEL_DEVSEL: begin
            step_next = (frame_ff.mode == MODE_LBA48) ? SEL_SECCOUNT_HI : SEL_SECCOUNT;
            value     = frame_ff.dev;
         end
         SEL_SECCOUNT_HI: begin
            step_next = SEL_LBA3;
            value     = 8'd0;
         end
         SEL_LBA3: begin
            step_next = SEL_LBA4;
            value     = frame_ff.b3;
         end
         SEL_LBA4: begin
            step_next = SEL_LBA5;
            value     = 8'd0;
         end
         SEL_LBA5: begin
            step_next = SEL_SECCOUNT;
            value     = 8'd0;
         end
         SEL_SECCOUNT: begin
            step_next = SEL_LBA0;
            value     = frame_ff.cnt;
         end
         SEL_LBA0: begin
            step_next = SEL_LBA1;
            value     = frame_ff.b0;
         end
         SEL_LBA1: begin
            step_next = SEL_LBA2;
            value     = frame_ff.b1;
         end
         SEL_LBA2: begin
            step_next = SEL_COMMAND;
            value     = frame_ff.b2;
         end
         SEL_COMMAND: begin
            step_next = SEL_DEVSEL;
            value     = frame_ff.cmd;
         end
         default: begin
            step_next = SEL_DEVSEL;
            value     = 8'd0;
         end
      endcase

      frame_in       = load ? frame : frame_ff;
      frame_valid_in = load ? 1'b1 : ((issue && at_cmd) ? 1'b0 : frame_valid_ff);
      step_in        = load ? SEL_DEVSEL : (issue ? step_next : step_ff);

      rsp_valid_in = issue ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = rsp_ff;
      if (issue) begin
         rsp_in.reg_select = step_ff;
         rsp_in.reg_value  = value;
         rsp_in.addr_mode  = frame_ff.mode;
         rsp_in.last       = at_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         step_ff        <= SEL_DEVSEL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_valid_ff <= frame_valid_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
